/* src/multi_stable_priority_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// multi_stable_priority_queue_core_defines
// Assertion macros for the priority queue core.
// ----------------------------------------------------------------------------
`ifndef MULTI_STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MULTI_STABLE_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define MSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSQ_ASSERT(lbl, clk, rstn, prop)
`define MSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/msq_pkg.sv */
// ----------------------------------------------------------------------------
// msq_pkg
// Types and codes for the multi-queue stable priority queue core.
// ----------------------------------------------------------------------------
package msq_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WB,
        S_RES
    } t_state;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    localparam logic [1:0] ST_SERVED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

/* src/multi_stable_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// multi_stable_priority_queue_core
// Several stable priority queues in one entry memory, sharing a ticket count.
//
//   channel  dir  tdata                      tuser
//   s        in   [1:0] queue, [5:2] prio    [0] opcode
//   m        out  [15:0] ticket              [1:0] status
//
// Insert: entry written at the tail of its queue.
// Serve: a linear scan over the n entries of the queue, n = occupancy, reads
// one entry per cycle through the single memory read port, then the tail
// entry is written into the served slot and the result waits for a free output.
// Reset clears occupancy and ticket count; no clearing pass.
// Input stalls while a serve runs or while a result is waiting to be taken.
// ----------------------------------------------------------------------------
`include "multi_stable_priority_queue_core_defines.svh"

module multi_stable_priority_queue_core #(
    parameter int NUM_QUEUES    = 3,
    parameter int QUEUE_DEPTH   = 256,
    parameter int PRIORITY_BITS = 4,
    parameter int TICKET_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [1:0] queue_sel, [5:2] priority_req
    input  logic        i_s_tuser,   // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] ticket
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int EW = PRIORITY_BITS + TICKET_BITS;
    localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
    localparam logic [3:0]             NQ_L  = 4'(NUM_QUEUES);
    localparam logic [CW-1:0]          DEP_L = CW'(QUEUE_DEPTH);
    localparam logic [TICKET_BITS-1:0] T_MAX = '1;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [TICKET_BITS-1:0]   tick;
    } t_entry;

    msq_pkg::t_state r_state, n_state;

    logic [EW-1:0]          r_mem [MD];
    t_entry                 r_rdata;
    logic [CW-1:0]          r_occ [NUM_QUEUES];
    logic [TICKET_BITS-1:0] r_tick;
    logic [QW-1:0]          r_q;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_rd_idx;
    logic                   r_rv;
    logic [IW-1:0]          r_cmp_idx;
    logic [IW-1:0]          r_best_idx;
    t_entry                 r_best;
    t_entry                 r_last;
    logic                   r_ovalid;
    logic [15:0]            r_otick;
    logic [1:0]             r_ostat;

    logic [1:0]             in_sel;
    logic [15:0]            in_pw;
    logic [PRIORITY_BITS-1:0] in_prio;
    logic                   in_valid_q;
    logic [QW-1:0]          in_q;
    logic                   accept;
    logic                   out_free;
    logic [TICKET_BITS-1:0] tick_nx;
    logic [CW-1:0]          occ_in;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic                   rd_issue;
    logic                   take_new;
    logic                   scan_last;
    logic [47:0]            res_wide;

    function automatic logic [AW-1:0] f_addr(input logic [QW-1:0] q, input logic [IW-1:0] i);
        logic [AW+QW+IW:0] a;
        a = (AW+QW+IW+1)'(q) * (AW+QW+IW+1)'(QUEUE_DEPTH) + (AW+QW+IW+1)'(i);
        return a[AW-1:0];
    endfunction

    assign in_sel     = i_s_tdata[1:0];
    assign in_pw      = 16'(i_s_tdata[5:2]);
    assign in_prio    = in_pw[PRIORITY_BITS-1:0];
    assign in_valid_q = (in_sel != 2'd0) && ({2'b00, in_sel} <= NQ_L);
    assign in_q       = QW'(in_sel - 2'd1);
    assign occ_in     = r_occ[in_q];
    assign out_free   = !r_ovalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign tick_nx    = (r_tick == T_MAX) ? r_tick : r_tick + 1'b1;
    assign rd_issue   = (r_state == msq_pkg::S_SCAN) && (r_rd_idx < r_n);
    assign mem_raddr  = f_addr(r_q, r_rd_idx[IW-1:0]);
    assign take_new   = (r_cmp_idx == '0) ||
                        (r_rdata.prio > r_best.prio) ||
                        ((r_rdata.prio == r_best.prio) && (r_rdata.tick < r_best.tick));
    assign scan_last  = r_rv && (CW'(r_cmp_idx) == r_n - 1'b1);
    assign res_wide   = 48'(r_best.tick);

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = f_addr(in_q, occ_in[IW-1:0]);
        mem_wdata  = {in_prio, tick_nx};
        case (r_state)
            msq_pkg::S_IDLE: begin
                o_s_tready = out_free;
                if (i_s_tvalid && out_free && in_valid_q) begin
                    if (i_s_tuser == msq_pkg::OP_INSERT) begin
                        mem_we = (occ_in < DEP_L);
                    end else if (occ_in != '0) begin
                        n_state = msq_pkg::S_SCAN;
                    end
                end
            end
            msq_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = msq_pkg::S_WB;
                end
            end
            msq_pkg::S_WB: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_q, r_best_idx);
                mem_wdata = r_last;
                n_state   = msq_pkg::S_RES;
            end
            msq_pkg::S_RES: begin
                if (out_free) begin
                    n_state = msq_pkg::S_IDLE;
                end
            end
            default: n_state = msq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msq_pkg::S_IDLE;
            r_tick   <= '0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_occ[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rv    <= rd_issue;
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                msq_pkg::S_IDLE: begin
                    if (accept) begin
                        if (i_s_tuser == msq_pkg::OP_INSERT) begin
                            r_tick <= tick_nx;
                            if (in_valid_q) begin
                                if (occ_in < DEP_L) begin
                                    r_occ[in_q] <= occ_in + 1'b1;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_otick  <= '0;
                                    r_ostat  <= msq_pkg::ST_FULL;
                                end
                            end
                        end else if (in_valid_q) begin
                            r_q      <= in_q;
                            r_n      <= occ_in;
                            r_rd_idx <= '0;
                            if (occ_in == '0) begin
                                r_ovalid <= 1'b1;
                                r_otick  <= '0;
                                r_ostat  <= msq_pkg::ST_EMPTY;
                            end
                        end
                    end
                end
                msq_pkg::S_SCAN: begin
                    if (rd_issue) begin
                        r_rd_idx  <= r_rd_idx + 1'b1;
                        r_cmp_idx <= r_rd_idx[IW-1:0];
                    end
                    if (r_rv) begin
                        if (take_new) begin
                            r_best     <= r_rdata;
                            r_best_idx <= r_cmp_idx;
                        end
                        r_last <= r_rdata;
                    end
                end
                msq_pkg::S_WB: begin
                    r_occ[r_q] <= r_n - 1'b1;
                end
                msq_pkg::S_RES: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_otick  <= res_wide[15:0];
                        r_ostat  <= msq_pkg::ST_SERVED;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_otick;
    assign o_m_tuser  = r_ostat;

    `MSQ_ASSERT(a_ready_idle, i_clk, i_rst_n, !o_s_tready || (r_state == msq_pkg::S_IDLE))
    `MSQ_ASSERT_NEXT(a_wb_res, i_clk, i_rst_n, r_state == msq_pkg::S_WB, r_state == msq_pkg::S_RES)
    `MSQ_ASSERT(a_scan_idx, i_clk, i_rst_n, !(r_rv && (r_state == msq_pkg::S_SCAN)) || (CW'(r_cmp_idx) < r_n))
    `MSQ_ASSERT(a_scan_n, i_clk, i_rst_n, (r_state == msq_pkg::S_IDLE) || ((r_n != '0) && (r_n <= DEP_L)))

endmodule
